// File: sv/butterworth_spectral_gain_core_macros.svh
// Assertion macros for the Butterworth spectral gain core.
// Included by the top level; no other dependencies.
`ifndef BUTTERWORTH_SPECTRAL_GAIN_CORE_MACROS_SVH
`define BUTTERWORTH_SPECTRAL_GAIN_CORE_MACROS_SVH

// Plain property, sampled on the clock, off while in reset.
`define BWSG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BWSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/bwsg_pkg.sv
// Shared constants and codes for the Butterworth spectral gain core.
// No dependencies.
package bwsg_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned MAX_ORDER_DEF  = 15;

  localparam int unsigned AMP_W      = 32;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ORDER_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_RAW_W  = AMP_W + GAIN_W;
  localparam int unsigned OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STEPS = 4;

  localparam logic [DIST_W-1:0]  RST_CUTOFF = 16'd16;
  localparam logic [ORDER_W-1:0] RST_ORDER  = 4'd1;
  localparam logic [DIST_W-1:0]  RST_BAND   = 16'd8;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOW_PASS    = 3'd0,
    KIND_HIGH_PASS   = 3'd1,
    KIND_BAND_REJECT = 3'd2,
    KIND_BAND_PASS   = 3'd3,
    KIND_NOTCH       = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND    = 3'd0,
    REG_CUTOFF  = 3'd1,
    REG_ORDER   = 3'd2,
    REG_BAND    = 3'd3,
    REG_NOTCH_U = 3'd4,
    REG_NOTCH_V = 3'd5
  } reg_idx_e;

endpackage

// File: sv/butterworth_spectral_gain_core.sv
// Butterworth spectral gain core: weights one spectrum coefficient per cycle.
// Pipeline of 8 + ceil(33/4) + MAX_ORDER + ceil(17/4) + 3 register stages (40 at defaults).
// Throughput: one request per cycle; the whole pipe holds only while a result waits.
// Reset (async, active low) clears the config registers to their defaults and all
//   stage valid bits; data registers are not reset.
`include "butterworth_spectral_gain_core_macros.svh"

module butterworth_spectral_gain_core #(
  parameter int unsigned COORD_BITS = bwsg_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_ORDER  = bwsg_pkg::MAX_ORDER_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [bwsg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bwsg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // coefficient in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // freq_u, freq_v (COORD_BITS each, signed), amplitude_in (32), zero pad
  input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  // weighted coefficient out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // amplitude_out (32), gain (17), zero pad
  output logic [bwsg_pkg::OUT_W-1:0]          m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Widths
  // ---------------------------------------------------------------------------
  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned AMP_W   = bwsg_pkg::AMP_W;
  localparam int unsigned GAIN_W  = bwsg_pkg::GAIN_W;
  localparam int unsigned SQ_W    = 2 * CB;        // u^2 + v^2
  localparam int unsigned DD_W    = 2 * CB + 2;    // notch distances
  localparam int unsigned DIFF_W  = (SQ_W > 32) ? SQ_W : 32;
  localparam int unsigned AB_W    = (2 * DD_W > 64) ? 2 * DD_W : 64;
  localparam int unsigned HI_W    = AB_W - 32;
  localparam int unsigned SH_W    = $clog2(HI_W + 1);
  localparam int unsigned ORD_W   = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);
  localparam int unsigned T_W     = 33;            // ratio, Q0.32 up to one
  localparam int unsigned E_W     = 34;            // 1 + p, up to two
  localparam int unsigned N2_W    = 50;            // second dividend
  localparam int unsigned STEPS   = bwsg_pkg::DIV_STEPS;
  localparam int unsigned D1_ST   = (T_W + STEPS - 1) / STEPS;
  localparam int unsigned D2_ST   = (GAIN_W + STEPS - 1) / STEPS;
  localparam int unsigned V_T     = 8 + D1_ST - 1;               // last divider-1 stage
  localparam int unsigned NST     = 8 + D1_ST + MAX_ORDER + D2_ST + 3;

  localparam logic [T_W-1:0]    ONE_Q32   = {1'b1, 32'b0};
  localparam logic [GAIN_W-1:0] ONE_Q16   = {1'b1, 16'b0};
  localparam logic [2*T_W-1:0]  RND_Q32   = (2*T_W)'(64'h8000_0000);

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic             bzero;    // divisor B is zero
    logic             a_small;  // A <= B
  } side_t;

  // ---------------------------------------------------------------------------
  // Config registers and derived constants
  // ---------------------------------------------------------------------------
  logic [bwsg_pkg::KIND_W-1:0]  kind_q;
  logic [bwsg_pkg::DIST_W-1:0]  d0_q, bw_q;
  logic [bwsg_pkg::ORDER_W-1:0] order_q;
  logic signed [CB-1:0]         nu_q, nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= bwsg_pkg::KIND_LOW_PASS;
      d0_q    <= bwsg_pkg::RST_CUTOFF;
      order_q <= bwsg_pkg::RST_ORDER;
      bw_q    <= bwsg_pkg::RST_BAND;
      nu_q    <= '0;
      nv_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bwsg_pkg::REG_KIND:    kind_q  <= cfg_data_i[bwsg_pkg::KIND_W-1:0];
        bwsg_pkg::REG_CUTOFF:  d0_q    <= cfg_data_i;
        bwsg_pkg::REG_ORDER:   order_q <= cfg_data_i[bwsg_pkg::ORDER_W-1:0];
        bwsg_pkg::REG_BAND:    bw_q    <= cfg_data_i;
        bwsg_pkg::REG_NOTCH_U: nu_q    <= cfg_data_i[CB-1:0];
        bwsg_pkg::REG_NOTCH_V: nv_q    <= cfg_data_i[CB-1:0];
        default: ;
      endcase
    end
  end

  // C = D0^2, W^2 and C^2 are registered from the config registers (C^2 from the registered C).
  logic [31:0] c_q, ww_q;
  logic [63:0] cc_q;

  always_ff @(posedge clk_i) begin
    c_q  <= 32'(d0_q) * 32'(d0_q);
    ww_q <= 32'(bw_q) * 32'(bw_q);
    cc_q <= 64'(c_q) * 64'(c_q);
  end

  // order clamped to what the power chain holds
  logic [ORD_W-1:0] n_sat;
  assign n_sat = (32'(order_q) > 32'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ORD_W'(order_q);

  // ---------------------------------------------------------------------------
  // Flow control: every stage moves together; a held output freezes the pipe.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic           adv;

  assign adv           = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture the request
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] in_u_q, in_v_q;
  logic [AMP_W-1:0]     in_amp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_u_q   <= s_axis_tdata[CB-1:0];
      in_v_q   <= s_axis_tdata[2*CB-1:CB];
      in_amp_q <= s_axis_tdata[2*CB+AMP_W-1:2*CB];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: squared distances to the center and to both notch points
  // ---------------------------------------------------------------------------
  logic signed [SQ_W-1:0] squ, sqv;
  logic signed [CB:0]     du1, dv1, du2, dv2;
  logic signed [DD_W-1:0] sq_u1, sq_v1, sq_u2, sq_v2;

  always_comb begin
    squ   = in_u_q * in_u_q;
    sqv   = in_v_q * in_v_q;
    du1   = $signed({in_u_q[CB-1], in_u_q}) - $signed({nu_q[CB-1], nu_q});
    dv1   = $signed({in_v_q[CB-1], in_v_q}) - $signed({nv_q[CB-1], nv_q});
    du2   = $signed({in_u_q[CB-1], in_u_q}) + $signed({nu_q[CB-1], nu_q});
    dv2   = $signed({in_v_q[CB-1], in_v_q}) + $signed({nv_q[CB-1], nv_q});
    sq_u1 = du1 * du1;
    sq_v1 = dv1 * dv1;
    sq_u2 = du2 * du2;
    sq_v2 = dv2 * dv2;
  end

  logic [SQ_W-1:0]  sq_d_q;
  logic [DD_W-1:0]  sq_d1_q, sq_d2_q;
  logic [AMP_W-1:0] sq_amp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_d_q   <= $unsigned(squ) + $unsigned(sqv);
      sq_d1_q  <= $unsigned(sq_u1) + $unsigned(sq_v1);
      sq_d2_q  <= $unsigned(sq_u2) + $unsigned(sq_v2);
      sq_amp_q <= in_amp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: |D - C| for the band kinds
  // ---------------------------------------------------------------------------
  logic [DIFF_W-1:0] dd_ext, c_ext;
  assign dd_ext = DIFF_W'(sq_d_q);
  assign c_ext  = DIFF_W'(c_q);

  logic [DIFF_W-1:0] df_diff_q;
  logic [SQ_W-1:0]   df_d_q;
  logic [DD_W-1:0]   df_d1_q, df_d2_q;
  logic [AMP_W-1:0]  df_amp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      df_diff_q <= (dd_ext >= c_ext) ? dd_ext - c_ext : c_ext - dd_ext;
      df_d_q    <= sq_d_q;
      df_d1_q   <= sq_d1_q;
      df_d2_q   <= sq_d2_q;
      df_amp_q  <= sq_amp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: band and notch products (three parallel multipliers)
  // ---------------------------------------------------------------------------
  logic [AB_W-1:0]  mu_pa_q, mu_pb_q, mu_pn_q;
  logic [SQ_W-1:0]  mu_d_q;
  logic [AMP_W-1:0] mu_amp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_pa_q  <= AB_W'(df_d_q) * AB_W'(ww_q);
      mu_pb_q  <= AB_W'(df_diff_q) * AB_W'(df_diff_q);
      mu_pn_q  <= AB_W'(df_d1_q) * AB_W'(df_d2_q);
      mu_d_q   <= df_d_q;
      mu_amp_q <= df_amp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: pick the ratio terms A / B for the configured kind
  // ---------------------------------------------------------------------------
  logic [AB_W-1:0] sel_a, sel_b;

  always_comb begin
    unique case (kind_q)
      bwsg_pkg::KIND_LOW_PASS: begin
        sel_a = AB_W'(mu_d_q);
        sel_b = AB_W'(c_q);
      end
      bwsg_pkg::KIND_HIGH_PASS: begin
        sel_a = AB_W'(c_q);
        sel_b = AB_W'(mu_d_q);
      end
      bwsg_pkg::KIND_BAND_REJECT, bwsg_pkg::KIND_BAND_PASS: begin
        sel_a = mu_pa_q;
        sel_b = mu_pb_q;
      end
      bwsg_pkg::KIND_NOTCH: begin
        sel_a = AB_W'(cc_q);
        sel_b = mu_pn_q;
      end
      default: begin
        // unknown kind: forced to unity gain at the end
        sel_a = '0;
        sel_b = AB_W'(1);
      end
    endcase
  end

  logic [AB_W-1:0]  se_a_q, se_b_q;
  logic [AMP_W-1:0] se_amp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      se_a_q   <= sel_a;
      se_b_q   <= sel_b;
      se_amp_q <= mu_amp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: order the terms, flag a zero divisor
  // ---------------------------------------------------------------------------
  logic            ab_le;
  assign ab_le = se_a_q <= se_b_q;

  logic [AB_W-1:0] or_mn_q, or_mx_q;
  side_t           or_sd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      or_mn_q         <= ab_le ? se_a_q : se_b_q;
      or_mx_q         <= ab_le ? se_b_q : se_a_q;
      or_sd_q.amp     <= se_amp_q;
      or_sd_q.bzero   <= se_b_q == '0;
      or_sd_q.a_small <= ab_le;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: shift count = bit length of the max above bit 31
  // ---------------------------------------------------------------------------
  logic [SH_W-1:0] lz_sh;

  always_comb begin
    lz_sh = '0;
    for (int b = 0; b < HI_W; b++) begin
      if (or_mx_q[32+b]) lz_sh = SH_W'(b + 1);
    end
  end

  logic [SH_W-1:0] lz_sh_q;
  logic [AB_W-1:0] lz_mn_q, lz_mx_q;
  side_t           lz_sd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lz_sh_q <= lz_sh;
      lz_mn_q <= or_mn_q;
      lz_mx_q <= or_mx_q;
      lz_sd_q <= or_sd_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: bring both terms below 2^32 (truncating shift)
  // ---------------------------------------------------------------------------
  logic [31:0] nm_mn_q, nm_mx_q;
  side_t       nm_sd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_mn_q <= 32'(lz_mn_q >> lz_sh_q);
      nm_mx_q <= 32'(lz_mx_q >> lz_sh_q);
      nm_sd_q <= lz_sd_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider 1: t = (m * 2^32 + M/2) / M, restoring, STEPS bits a stage.
  // The dividend's top part (m >> 1) is already below M; its low 33 bits
  // are m[0], 0, M[31:1] since M/2 cannot carry into bit 32.
  // ---------------------------------------------------------------------------
  logic [31:0]    d1_r_q  [D1_ST];
  logic [T_W-1:0] d1_nb_q [D1_ST];
  logic [T_W-1:0] d1_q_q  [D1_ST];
  logic [31:0]    d1_dv_q [D1_ST];
  side_t          d1_sd_q [D1_ST];

  for (genvar k = 0; k < D1_ST; k++) begin : g_div1
    logic [31:0]    r_in, dv_in, r_d;
    logic [T_W-1:0] nb_in, q_in, nb_d, q_d;
    logic [32:0]    r_x;
    side_t          s_in;

    if (k == 0) begin : g_first
      assign r_in  = {1'b0, nm_mn_q[31:1]};
      assign nb_in = {nm_mn_q[0], 1'b0, nm_mx_q[31:1]};
      assign q_in  = '0;
      assign dv_in = nm_mx_q;
      assign s_in  = nm_sd_q;
    end else begin : g_next
      assign r_in  = d1_r_q[k-1];
      assign nb_in = d1_nb_q[k-1];
      assign q_in  = d1_q_q[k-1];
      assign dv_in = d1_dv_q[k-1];
      assign s_in  = d1_sd_q[k-1];
    end

    always_comb begin
      r_d  = r_in;
      nb_d = nb_in;
      q_d  = q_in;
      r_x  = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < T_W) begin
          r_x  = {r_d, nb_d[T_W-1]};
          nb_d = nb_d << 1;
          if (r_x >= {1'b0, dv_in}) begin
            q_d = {q_d[T_W-2:0], 1'b1};
            r_d = 32'(r_x - {1'b0, dv_in});
          end else begin
            q_d = {q_d[T_W-2:0], 1'b0};
            r_d = r_x[31:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_r_q[k]  <= r_d;
        d1_nb_q[k] <= nb_d;
        d1_q_q[k]  <= q_d;
        d1_dv_q[k] <= dv_in;
        d1_sd_q[k] <= s_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Power chain: p = t^n in Q0.32, one rounded multiply per stage; stage i
  // acts only while i < n, and never when t is exactly one.
  // ---------------------------------------------------------------------------
  logic [T_W-1:0] pw_p_q  [MAX_ORDER];
  logic [T_W-1:0] pw_t_q  [MAX_ORDER];
  side_t          pw_sd_q [MAX_ORDER];

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_pow
    logic [T_W-1:0]   p_in, t_in, p_d;
    logic [2*T_W-1:0] prod;
    side_t            s_in;

    if (i == 0) begin : g_first
      assign p_in = ONE_Q32;
      assign t_in = d1_q_q[D1_ST-1];
      assign s_in = d1_sd_q[D1_ST-1];
    end else begin : g_next
      assign p_in = pw_p_q[i-1];
      assign t_in = pw_t_q[i-1];
      assign s_in = pw_sd_q[i-1];
    end

    always_comb begin
      prod = (2*T_W)'(p_in) * (2*T_W)'(t_in[T_W-2:0]) + RND_Q32;
      p_d  = p_in;
      if ((ORD_W'(i) < n_sat) && !t_in[T_W-1]) p_d = T_W'(prod >> 32);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pw_p_q[i]  <= p_d;
        pw_t_q[i]  <= t_in;
        pw_sd_q[i] <= s_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider 2: gain = (2^48 or p * 2^16, plus E/2) / E with E = 2^32 + p.
  // Quotient fits 17 bits, so the top part N >> 17 starts below E.
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]  p_fin;
  logic [E_W-1:0]  e_fin;
  logic [N2_W-1:0] n2;

  assign p_fin = pw_p_q[MAX_ORDER-1];
  assign e_fin = E_W'(ONE_Q32) + E_W'(p_fin);
  assign n2    = pw_sd_q[MAX_ORDER-1].a_small ?
                 (N2_W'(1) << 48) + N2_W'(e_fin >> 1) :
                 (N2_W'(p_fin) << 16) + N2_W'(e_fin >> 1);

  logic [E_W-1:0]    d2_r_q  [D2_ST];
  logic [GAIN_W-1:0] d2_nb_q [D2_ST];
  logic [GAIN_W-1:0] d2_q_q  [D2_ST];
  logic [E_W-1:0]    d2_dv_q [D2_ST];
  side_t             d2_sd_q [D2_ST];

  for (genvar k = 0; k < D2_ST; k++) begin : g_div2
    logic [E_W-1:0]    r_in, dv_in, r_d;
    logic [GAIN_W-1:0] nb_in, q_in, nb_d, q_d;
    logic [E_W:0]      r_x;
    side_t             s_in;

    if (k == 0) begin : g_first
      assign r_in  = E_W'(n2 >> GAIN_W);
      assign nb_in = n2[GAIN_W-1:0];
      assign q_in  = '0;
      assign dv_in = e_fin;
      assign s_in  = pw_sd_q[MAX_ORDER-1];
    end else begin : g_next
      assign r_in  = d2_r_q[k-1];
      assign nb_in = d2_nb_q[k-1];
      assign q_in  = d2_q_q[k-1];
      assign dv_in = d2_dv_q[k-1];
      assign s_in  = d2_sd_q[k-1];
    end

    always_comb begin
      r_d  = r_in;
      nb_d = nb_in;
      q_d  = q_in;
      r_x  = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < GAIN_W) begin
          r_x  = {r_d, nb_d[GAIN_W-1]};
          nb_d = nb_d << 1;
          if (r_x >= {1'b0, dv_in}) begin
            q_d = {q_d[GAIN_W-2:0], 1'b1};
            r_d = E_W'(r_x - {1'b0, dv_in});
          end else begin
            q_d = {q_d[GAIN_W-2:0], 1'b0};
            r_d = r_x[E_W-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_r_q[k]  <= r_d;
        d2_nb_q[k] <= nb_d;
        d2_q_q[k]  <= q_d;
        d2_dv_q[k] <= dv_in;
        d2_sd_q[k] <= s_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gain stage: unknown kinds pass with unity, a zero divisor gives zero (unity for
  // band pass), and band pass is the complement of band reject.
  // ---------------------------------------------------------------------------
  logic              kind_known;
  logic [GAIN_W-1:0] g_raw, g_fin;

  assign kind_known = kind_q <= bwsg_pkg::KIND_NOTCH;

  always_comb begin
    if (!kind_known) begin
      g_raw = ONE_Q16;
    end else if (d2_sd_q[D2_ST-1].bzero) begin
      g_raw = '0;
    end else begin
      g_raw = d2_q_q[D2_ST-1];
    end
    g_fin = (kind_q == bwsg_pkg::KIND_BAND_PASS) ? ONE_Q16 - g_raw : g_raw;
  end

  logic [GAIN_W-1:0] gn_g_q;
  logic [AMP_W-1:0]  gn_amp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gn_g_q   <= g_fin;
      gn_amp_q <= d2_sd_q[D2_ST-1].amp;
    end
  end

  // ---------------------------------------------------------------------------
  // Weighting multiply, then round and saturate into the output register
  // ---------------------------------------------------------------------------
  logic [AMP_W+GAIN_W-1:0] pr_prod_q;
  logic [GAIN_W-1:0]       pr_g_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_prod_q <= (AMP_W+GAIN_W)'(gn_amp_q) * (AMP_W+GAIN_W)'(gn_g_q);
      pr_g_q    <= gn_g_q;
    end
  end

  logic [AMP_W:0] rnd;
  assign rnd = (AMP_W+1)'((pr_prod_q + (AMP_W+GAIN_W)'(32768)) >> 16);

  logic [AMP_W-1:0]  out_amp_q;
  logic [GAIN_W-1:0] out_gain_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_amp_q  <= rnd[AMP_W] ? '1 : rnd[AMP_W-1:0];
      out_gain_q <= pr_g_q;
    end
  end

  assign m_axis_tdata = {(bwsg_pkg::OUT_W - bwsg_pkg::OUT_RAW_W)'(0), out_gain_q, out_amp_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BWSG_ASSERT_IMP(a_ratio_max, clk_i, rst_ni, vld_q[V_T] && !d1_sd_q[D1_ST-1].bzero, d1_q_q[D1_ST-1] <= ONE_Q32, "ratio above one after divider")
  `BWSG_ASSERT(a_gain_max, clk_i, rst_ni, !m_axis_tvalid || (out_gain_q <= ONE_Q16), "gain above one")
  `BWSG_ASSERT_IMP(a_zero_gain, clk_i, rst_ni, m_axis_tvalid && (out_gain_q == '0), out_amp_q == '0, "zero gain with nonzero amplitude")

endmodule
